// ===== sv/dgf_pkg.sv =====
// Shared types and constants for the direct gravity force sum unit.
`default_nettype none

package dgf_pkg;

    localparam int MAX_STARS_DEF = 64;
    localparam int POS_W         = 16;
    localparam int MASS_W        = 24;
    localparam int FORCE_W       = 48;
    localparam int IDX_W         = 6;

    // Accumulator limit, units of 2^-48
    localparam logic [63:0] ACC_MAX     = 64'h3FFF_FFFF_FFFF_FFFF;
    // round(2^32 / (4*pi))
    localparam logic [31:0] INV_4PI_Q32 = 32'd341782638;

    typedef struct packed {
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [MASS_W-1:0] mass;
    } star_t;

endpackage

`default_nettype wire

// ===== sv/dgf_star_mem.sv =====
// Star store: one write port, one registered read port.
`default_nettype none

module dgf_star_mem #(
    parameter int DEPTH = dgf_pkg::MAX_STARS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic           clk,
    input  wire logic           wr_en,
    input  wire logic [AW-1:0]  wr_addr,
    input  wire dgf_pkg::star_t wr_data,
    input  wire logic           rd_en,
    input  wire logic [AW-1:0]  rd_addr,
    output dgf_pkg::star_t      rd_data
);
    import dgf_pkg::*;

    star_t mem [DEPTH];

    // Write a loaded star
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/dgf_isqrt.sv =====
// Iterative integer square root, one result bit per cycle.
`default_nettype none

module dgf_isqrt (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] val,
    output logic             busy,
    output logic [31:0]      root
);
    import dgf_pkg::*;

    logic        busy_reg, busy_next;
    logic [63:0] v_reg, v_next;
    logic [63:0] res_reg, res_next;
    logic [63:0] bit_reg, bit_next;
    logic [64:0] trial;

    assign trial = {1'b0, res_reg} + {1'b0, bit_reg};

    // Step the digit-by-digit root
    always_comb
    begin
        busy_next = busy_reg;
        v_next    = v_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        if (start)
        begin
            busy_next = 1'b1;
            v_next    = val;
            res_next  = '0;
            bit_next  = 64'h4000_0000_0000_0000;
        end
        else if (busy_reg)
        begin
            if ({1'b0, v_reg} >= trial)
            begin
                v_next   = v_reg - trial[63:0];
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0])
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign busy = busy_reg;
    assign root = res_reg[31:0];

endmodule

`default_nettype wire

// ===== sv/dgf_div.sv =====
// Restoring divider, 128 by 64 bits, quotient saturated to 64 bits.
`default_nettype none

module dgf_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] num_hi,
    input  wire logic [63:0] num_lo,
    input  wire logic [63:0] den,
    output logic             busy,
    output logic [63:0]      quo
);
    import dgf_pkg::*;

    logic        busy_reg, busy_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] lo_reg, lo_next;
    logic [63:0] q_reg, q_next;
    logic [63:0] d_reg, d_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [64:0] shifted;
    logic [64:0] diff;

    assign shifted = {rem_reg, lo_reg[63]};
    assign diff    = shifted - {1'b0, d_reg};

    // Shift in one numerator bit and subtract when it fits
    always_comb
    begin
        busy_next = busy_reg;
        rem_next  = rem_reg;
        lo_next   = lo_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            d_next = den;
            if (num_hi >= den)
            begin
                q_next = '1;
            end
            else
            begin
                busy_next = 1'b1;
                rem_next  = num_hi;
                lo_next   = num_lo;
                q_next    = '0;
                cnt_next  = '1;
            end
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, d_reg})
            begin
                rem_next = diff[63:0];
                q_next   = {q_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[63:0];
                q_next   = {q_reg[62:0], 1'b0};
            end
            lo_next  = {lo_reg[62:0], 1'b0};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        lo_reg  <= lo_next;
        q_reg   <= q_next;
        d_reg   <= d_next;
        cnt_reg <= cnt_next;
    end

    assign busy = busy_reg;
    assign quo  = q_reg;

endmodule

`default_nettype wire

// ===== sv/dgf_wmul.sv =====
// Wide by narrow multiplier, one 32 by 32 partial product per cycle.
`default_nettype none

module dgf_wmul (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [95:0]  a,
    input  wire logic [31:0]  b,
    output logic              busy,
    output logic [127:0]      prod
);
    import dgf_pkg::*;

    logic         busy_reg, busy_next;
    logic [95:0]  a_reg, a_next;
    logic [31:0]  b_reg, b_next;
    logic [127:0] acc_reg, acc_next;
    logic [1:0]   cnt_reg, cnt_next;
    logic [63:0]  pp;

    // Top chunk first; shift the running sum up one chunk per step
    assign pp = 64'(a_reg[95:64]) * 64'(b_reg);

    always_comb
    begin
        busy_next = busy_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            a_next    = a;
            b_next    = b;
            acc_next  = '0;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            acc_next = (acc_reg << 32) + {64'b0, pp};
            a_next   = {a_reg[63:0], 32'b0};
            cnt_next = cnt_reg + 2'd1;
            if (cnt_reg == 2'd2)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
        cnt_reg <= cnt_next;
    end

    assign busy = busy_reg;
    assign prod = acc_reg;

endmodule

`default_nettype wire

// ===== sv/direct_gravity_force_sum_unit.sv =====
// Top level: star store, pair sequencer and force finishing.
//
//  Channel | Direction | Handshake             | Payload
//  --------+-----------+-----------------------+---------------------------------------
//  in      | input     | in_valid / in_ready   | pos_x, pos_y, star_mass, last_star
//  out     | output    | out_valid / out_ready | force_x, force_y, star_index,
//          |           |                       | coincident_flag, saturated_flag,
//          |           |                       | last_result
//
// A star request without last_star stores the star while the store has room.
// A request with last_star starts the sweep: N stars give N results, each result
// walks the other N-1 stars. Each pair goes through the square root and then the
// two dividers, which divide the two force components in parallel; a coincident
// pair skips both, and a saturating quotient ends the division early.
// Reset clears the sequencer and the star count; the store itself needs no clear.
// The sweep holds before loading a result while the previous one is not taken;
// no new star is taken until the last result is loaded.
`default_nettype none

module direct_gravity_force_sum_unit #(
    parameter int MAX_STARS = dgf_pkg::MAX_STARS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [dgf_pkg::POS_W-1:0]     pos_x,
    input  wire logic [dgf_pkg::POS_W-1:0]     pos_y,
    input  wire logic [dgf_pkg::MASS_W-1:0]    star_mass,
    input  wire logic                          last_star,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [dgf_pkg::FORCE_W-1:0] force_x,
    output logic signed [dgf_pkg::FORCE_W-1:0] force_y,
    output logic [dgf_pkg::IDX_W-1:0]          star_index,
    output logic                               coincident_flag,
    output logic                               saturated_flag,
    output logic                               last_result
);
    import dgf_pkg::*;

    localparam int AW = $clog2(MAX_STARS);
    localparam int CW = $clog2(MAX_STARS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_STARS);

    localparam logic signed [64:0] SUM_MAX = 65'sh0_3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [64:0] SUM_MIN = -SUM_MAX;
    localparam logic [127:0]       ROUND_HALF = 128'h1 << 55;
    localparam logic [71:0]        LIM_POS = 72'h7FFF_FFFF_FFFF;
    localparam logic [71:0]        LIM_NEG = 72'h8000_0000_0000;

    localparam logic [3:0] S_LOAD = 4'd0;
    localparam logic [3:0] S_RDJ  = 4'd1;
    localparam logic [3:0] S_CAPJ = 4'd2;
    localparam logic [3:0] S_RDI  = 4'd3;
    localparam logic [3:0] S_DIF  = 4'd4;
    localparam logic [3:0] S_SQ   = 4'd5;
    localparam logic [3:0] S_CHK  = 4'd6;
    localparam logic [3:0] S_SQRT = 4'd7;
    localparam logic [3:0] S_DEN  = 4'd8;
    localparam logic [3:0] S_DVS  = 4'd9;
    localparam logic [3:0] S_DIV  = 4'd10;
    localparam logic [3:0] S_ACC  = 4'd11;
    localparam logic [3:0] S_FM1  = 4'd12;
    localparam logic [3:0] S_FM2  = 4'd13;
    localparam logic [3:0] S_RND  = 4'd14;
    localparam logic [3:0] S_OUT  = 4'd15;

    // Control state
    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          out_valid_reg, out_valid_next;

    // Sweep state
    logic [AW-1:0]        j_reg, j_next;
    logic [CW-1:0]        i_reg, i_next;
    logic [POS_W-1:0]     xj_reg, xj_next, yj_reg, yj_next;
    logic [MASS_W-1:0]    mj_reg, mj_next, mi_reg, mi_next;
    logic signed [16:0]   dx_reg, dx_next, dy_reg, dy_next;
    logic [32:0]          r2_reg, r2_next;
    logic [39:0]          vx_reg, vx_next, vy_reg, vy_next;
    logic [63:0]          den_reg, den_next;
    logic signed [63:0]   accx_reg, accx_next, accy_reg, accy_next;
    logic                 coin_reg, coin_next, sat_reg, sat_next;
    logic                 comp_reg, comp_next, neg_reg, neg_next;
    logic [FORCE_W-1:0]   fx_reg, fx_next, fy_reg, fy_next;

    // Result register
    logic [FORCE_W-1:0] ofx_reg, ofx_next, ofy_reg, ofy_next;
    logic [IDX_W-1:0]   oidx_reg, oidx_next;
    logic               ocoin_reg, ocoin_next, osat_reg, osat_next;
    logic               olast_reg, olast_next;

    // Store and units
    logic          wr_en, rd_en;
    logic [AW-1:0] rd_addr;
    star_t         wr_data, rd_data;
    logic          sq_start, sq_busy;
    logic [31:0]   sq_root;
    logic          dv_start, dvx_busy, dvy_busy;
    logic [63:0]   qx, qy;
    logic          wm_start, wm_busy;
    logic [95:0]   wm_a;
    logic [31:0]   wm_b;
    logic [127:0]  wm_prod;

    // Datapath helpers
    logic [15:0]         adx, ady;
    logic signed [33:0]  sqx, sqy;
    logic [63:0]         tmx, tmy;
    logic                clipx, clipy;
    logic signed [63:0]  termx, termy;
    logic signed [64:0]  sumx, sumy;
    logic [63:0]         accx_mag, accy_mag;
    logic [127:0]        rp;
    logic [71:0]         qv, lim;
    logic                fin_clip;
    logic [FORCE_W-1:0]  rmag, fin_val;
    logic                last_j;

    assign in_ready = (state_reg == S_LOAD);
    assign wr_en    = in_valid && in_ready && (count_reg < MAX_CNT);
    assign wr_data  = '{x: pos_x, y: pos_y, mass: star_mass};

    dgf_star_mem #(
        .DEPTH (MAX_STARS),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    dgf_isqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .val   ({3'b0, r2_reg, 28'b0}),
        .busy  (sq_busy),
        .root  (sq_root)
    );

    dgf_div u_divx (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (dv_start),
        .num_hi (64'(vx_reg[39:2])),
        .num_lo ({vx_reg[1:0], 62'b0}),
        .den    (den_reg),
        .busy   (dvx_busy),
        .quo    (qx)
    );

    dgf_div u_divy (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (dv_start),
        .num_hi (64'(vy_reg[39:2])),
        .num_lo ({vy_reg[1:0], 62'b0}),
        .den    (den_reg),
        .busy   (dvy_busy),
        .quo    (qy)
    );

    dgf_wmul u_wmul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (wm_start),
        .a     (wm_a),
        .b     (wm_b),
        .busy  (wm_busy),
        .prod  (wm_prod)
    );

    // Pair geometry
    assign adx = dx_reg[16] ? 16'(-dx_reg) : dx_reg[15:0];
    assign ady = dy_reg[16] ? 16'(-dy_reg) : dy_reg[15:0];
    assign sqx = dx_reg * dx_reg;
    assign sqy = dy_reg * dy_reg;

    // Clip terms, apply sign, saturating add
    assign clipx = (qx > ACC_MAX);
    assign clipy = (qy > ACC_MAX);
    assign tmx   = clipx ? ACC_MAX : qx;
    assign tmy   = clipy ? ACC_MAX : qy;
    assign termx = dx_reg[16] ? -$signed(tmx) : $signed(tmx);
    assign termy = dy_reg[16] ? -$signed(tmy) : $signed(tmy);
    assign sumx  = $signed({accx_reg[63], accx_reg}) + $signed({termx[63], termx});
    assign sumy  = $signed({accy_reg[63], accy_reg}) + $signed({termy[63], termy});

    // Finish: round half away, clip to field limit, apply sign
    assign accx_mag = accx_reg[63] ? (~accx_reg + 64'd1) : accx_reg;
    assign accy_mag = accy_reg[63] ? (~accy_reg + 64'd1) : accy_reg;
    assign rp       = wm_prod + ROUND_HALF;
    assign qv       = rp[127:56];
    assign lim      = neg_reg ? LIM_NEG : LIM_POS;
    assign fin_clip = (qv > lim);
    assign rmag     = fin_clip ? lim[FORCE_W-1:0] : qv[FORCE_W-1:0];
    assign fin_val  = neg_reg ? (48'd0 - rmag) : rmag;

    assign last_j = ((CW'(j_reg) + CW'(1)) == count_reg);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        j_next         = j_reg;
        i_next         = i_reg;
        xj_next        = xj_reg;
        yj_next        = yj_reg;
        mj_next        = mj_reg;
        mi_next        = mi_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        r2_next        = r2_reg;
        vx_next        = vx_reg;
        vy_next        = vy_reg;
        den_next       = den_reg;
        accx_next      = accx_reg;
        accy_next      = accy_reg;
        coin_next      = coin_reg;
        sat_next       = sat_reg;
        comp_next      = comp_reg;
        neg_next       = neg_reg;
        fx_next        = fx_reg;
        fy_next        = fy_reg;
        ofx_next       = ofx_reg;
        ofy_next       = ofy_reg;
        oidx_next      = oidx_reg;
        ocoin_next     = ocoin_reg;
        osat_next      = osat_reg;
        olast_next     = olast_reg;
        rd_en          = 1'b0;
        rd_addr        = j_reg;
        sq_start       = 1'b0;
        dv_start       = 1'b0;
        wm_start       = 1'b0;
        wm_a           = '0;
        wm_b           = '0;

        // Drop a taken result
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_LOAD:
            begin
                if (in_valid)
                begin
                    if (count_reg < MAX_CNT)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                    if (last_star)
                    begin
                        j_next     = '0;
                        state_next = S_RDJ;
                    end
                end
            end
            S_RDJ:
            begin
                rd_en      = 1'b1;
                rd_addr    = j_reg;
                state_next = S_CAPJ;
            end
            S_CAPJ:
            begin
                xj_next    = rd_data.x;
                yj_next    = rd_data.y;
                mj_next    = rd_data.mass;
                accx_next  = '0;
                accy_next  = '0;
                coin_next  = 1'b0;
                sat_next   = 1'b0;
                i_next     = '0;
                state_next = S_RDI;
            end
            S_RDI:
            begin
                if (i_reg == count_reg)
                begin
                    wm_start   = 1'b1;
                    wm_a       = {32'b0, accx_mag};
                    wm_b       = {8'b0, mj_reg};
                    neg_next   = accx_reg[63];
                    comp_next  = 1'b0;
                    state_next = S_FM1;
                end
                else if (i_reg == CW'(j_reg))
                begin
                    i_next = i_reg + CW'(1);
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = i_reg[AW-1:0];
                    state_next = S_DIF;
                end
            end
            S_DIF:
            begin
                dx_next    = $signed({1'b0, rd_data.x}) - $signed({1'b0, xj_reg});
                dy_next    = $signed({1'b0, rd_data.y}) - $signed({1'b0, yj_reg});
                mi_next    = rd_data.mass;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                r2_next    = 33'(sqx) + 33'(sqy);
                vx_next    = 40'(adx) * 40'(mi_reg);
                vy_next    = 40'(ady) * 40'(mi_reg);
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (r2_reg == '0)
                begin
                    coin_next  = 1'b1;
                    i_next     = i_reg + CW'(1);
                    state_next = S_RDI;
                end
                else
                begin
                    sq_start   = 1'b1;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (!sq_busy)
                begin
                    state_next = S_DEN;
                end
            end
            S_DEN:
            begin
                den_next   = 64'(r2_reg) * 64'(sq_root[30:0]);
                state_next = S_DVS;
            end
            S_DVS:
            begin
                dv_start   = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (!dvx_busy && !dvy_busy)
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                if (sumx > SUM_MAX)
                begin
                    accx_next = $signed(ACC_MAX);
                end
                else if (sumx < SUM_MIN)
                begin
                    accx_next = -$signed(ACC_MAX);
                end
                else
                begin
                    accx_next = sumx[63:0];
                end
                if (sumy > SUM_MAX)
                begin
                    accy_next = $signed(ACC_MAX);
                end
                else if (sumy < SUM_MIN)
                begin
                    accy_next = -$signed(ACC_MAX);
                end
                else
                begin
                    accy_next = sumy[63:0];
                end
                if (clipx || clipy || sumx > SUM_MAX || sumx < SUM_MIN
                    || sumy > SUM_MAX || sumy < SUM_MIN)
                begin
                    sat_next = 1'b1;
                end
                i_next     = i_reg + CW'(1);
                state_next = S_RDI;
            end
            S_FM1:
            begin
                if (!wm_busy)
                begin
                    wm_start   = 1'b1;
                    wm_a       = wm_prod[95:0];
                    wm_b       = INV_4PI_Q32;
                    state_next = S_FM2;
                end
            end
            S_FM2:
            begin
                if (!wm_busy)
                begin
                    state_next = S_RND;
                end
            end
            S_RND:
            begin
                if (fin_clip)
                begin
                    sat_next = 1'b1;
                end
                if (!comp_reg)
                begin
                    fx_next    = fin_val;
                    comp_next  = 1'b1;
                    neg_next   = accy_reg[63];
                    wm_start   = 1'b1;
                    wm_a       = {32'b0, accy_mag};
                    wm_b       = {8'b0, mj_reg};
                    state_next = S_FM1;
                end
                else
                begin
                    fy_next    = fin_val;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // Hold until the result register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    ofx_next       = fx_reg;
                    ofy_next       = fy_reg;
                    oidx_next      = IDX_W'(j_reg);
                    ocoin_next     = coin_reg;
                    osat_next      = sat_reg;
                    olast_next     = last_j;
                    if (last_j)
                    begin
                        count_next = '0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        j_next     = j_reg + AW'(1);
                        state_next = S_RDJ;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        j_reg     <= j_next;
        i_reg     <= i_next;
        xj_reg    <= xj_next;
        yj_reg    <= yj_next;
        mj_reg    <= mj_next;
        mi_reg    <= mi_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        r2_reg    <= r2_next;
        vx_reg    <= vx_next;
        vy_reg    <= vy_next;
        den_reg   <= den_next;
        accx_reg  <= accx_next;
        accy_reg  <= accy_next;
        coin_reg  <= coin_next;
        sat_reg   <= sat_next;
        comp_reg  <= comp_next;
        neg_reg   <= neg_next;
        fx_reg    <= fx_next;
        fy_reg    <= fy_next;
        ofx_reg   <= ofx_next;
        ofy_reg   <= ofy_next;
        oidx_reg  <= oidx_next;
        ocoin_reg <= ocoin_next;
        osat_reg  <= osat_next;
        olast_reg <= olast_next;
    end

    assign out_valid       = out_valid_reg;
    assign force_x         = ofx_reg;
    assign force_y         = ofy_reg;
    assign star_index      = oidx_reg;
    assign coincident_flag = ocoin_reg;
    assign saturated_flag  = osat_reg;
    assign last_result     = olast_reg;

    // Units are quiet whenever stars are being loaded
    a_units_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD) |-> (!sq_busy && !dvx_busy && !dvy_busy && !wm_busy))
        else $error("arithmetic unit busy while loading stars");

    // Star count never passes the store depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("star count beyond store depth");

    // Every store read hits a loaded entry
    a_read_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (CW'(rd_addr) < count_reg))
        else $error("store read beyond loaded stars");

endmodule

`default_nettype wire
